>>> rtl/core/ial_pkg.sv
// Shared types and constants for the indexed array list unit.
// Used by ial_ctrl and indexed_array_list_unit; no dependencies.
package ial_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_GET    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [FILL_W-1:0]   fill_level;
  } res_t;

endpackage

>>> rtl/core/ial_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ial_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/ial_ctrl.sv
// Request sequencer: decodes one request, shifts entries one per cycle through
// the RAM ports and keeps the fill count. Depends on ial_pkg.
module ial_ctrl #(
  parameter int CAPACITY   = ial_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ial_pkg::DATA_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ial_pkg::req_t         req_in,
  output logic                  res_valid,
  input  logic                  res_take,
  output ial_pkg::res_t         res,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [DATA_WIDTH-1:0] rd_data
);

  localparam int XW = ((CW > ial_pkg::POS_W) ? CW : ial_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    IDLE, DECIDE, SHIFT_UP, PLACE, SHIFT_DN, GET_WAIT, DONE
  } state_t;

  state_t                         state;
  ial_pkg::req_t                  req;
  logic [CW-1:0]                  count;
  logic [AW-1:0]                  idx;
  logic [ial_pkg::STATUS_W-1:0]   status;
  logic [ial_pkg::VALUE_W-1:0]    rdv;

  logic [XW-1:0]         posx, cntx, idxx;
  logic [AW-1:0]         pos_a, idx_dn, idx_up;
  logic                  full;
  logic [63:0]           word_wide, rd_wide;
  logic [DATA_WIDTH-1:0] word_st;

  assign posx      = XW'(req.position);
  assign cntx      = XW'(count);
  assign idxx      = XW'(idx);
  assign pos_a     = AW'(req.position);
  assign idx_dn    = idx - AW'(1);
  assign idx_up    = idx + AW'(1);
  assign full      = (count == CW'(CAPACITY));
  assign word_wide = 64'($signed(req.value));
  assign word_st   = word_wide[DATA_WIDTH-1:0];
  assign rd_wide   = 64'($signed(rd_data));

  assign in_ready       = (state == IDLE);
  assign res_valid      = (state == DONE);
  assign res.status     = status;
  assign res.read_value = rdv;
  assign res.fill_level = ial_pkg::FILL_W'(count);

  // RAM port control for the current step
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = pos_a;
    case (state)
      DECIDE: begin
        case (req.op)
          ial_pkg::OP_APPEND: begin
            wr_en   = !full;
            wr_addr = AW'(count);
            wr_data = word_st;
          end
          ial_pkg::OP_INSERT: begin
            if (!full && posx == cntx) begin
              wr_en   = 1'b1;
              wr_addr = pos_a;
              wr_data = word_st;
            end else if (!full && posx < cntx) begin
              rd_en   = 1'b1;
              rd_addr = AW'(count - CW'(1));
            end
          end
          ial_pkg::OP_DELETE: begin
            if (posx + XW'(1) < cntx) begin
              rd_en   = 1'b1;
              rd_addr = pos_a + AW'(1);
            end
          end
          default: begin
            rd_en = (posx < cntx);
          end
        endcase
      end
      SHIFT_UP: begin
        wr_en = 1'b1;
        if (XW'(idx_dn) > posx) begin
          rd_en   = 1'b1;
          rd_addr = idx - AW'(2);
        end
      end
      PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_a;
        wr_data = word_st;
      end
      SHIFT_DN: begin
        wr_en = 1'b1;
        if (idxx + XW'(2) < cntx) begin
          rd_en   = 1'b1;
          rd_addr = idx + AW'(2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            req   <= req_in;
            state <= DECIDE;
          end
        end
        DECIDE: begin
          rdv   <= '0;
          state <= DONE;
          case (req.op)
            ial_pkg::OP_APPEND: begin
              if (full) begin
                status <= ial_pkg::ST_FULL;
              end else begin
                status <= ial_pkg::ST_OK;
                count  <= count + CW'(1);
              end
            end
            ial_pkg::OP_INSERT: begin
              if (full) begin
                status <= ial_pkg::ST_FULL;
              end else if (posx > cntx) begin
                status <= ial_pkg::ST_RANGE;
              end else if (posx == cntx) begin
                status <= ial_pkg::ST_OK;
                count  <= count + CW'(1);
              end else begin
                idx   <= AW'(count);
                state <= SHIFT_UP;
              end
            end
            ial_pkg::OP_DELETE: begin
              if (posx >= cntx) begin
                status <= ial_pkg::ST_RANGE;
              end else if (posx + XW'(1) == cntx) begin
                status <= ial_pkg::ST_OK;
                count  <= count - CW'(1);
              end else begin
                idx   <= pos_a;
                state <= SHIFT_DN;
              end
            end
            default: begin
              if (posx >= cntx) begin
                status <= ial_pkg::ST_RANGE;
              end else begin
                state <= GET_WAIT;
              end
            end
          endcase
        end
        SHIFT_UP: begin
          // advance down toward the insert position
          if (XW'(idx_dn) > posx) begin
            idx <= idx_dn;
          end else begin
            state <= PLACE;
          end
        end
        PLACE: begin
          status <= ial_pkg::ST_OK;
          count  <= count + CW'(1);
          state  <= DONE;
        end
        SHIFT_DN: begin
          if (idxx + XW'(2) < cntx) begin
            idx <= idx_up;
          end else begin
            status <= ial_pkg::ST_OK;
            count  <= count - CW'(1);
            state  <= DONE;
          end
        end
        GET_WAIT: begin
          rdv    <= rd_wide[ial_pkg::VALUE_W-1:0];
          status <= ial_pkg::ST_OK;
          state  <= DONE;
        end
        DONE: begin
          // hold the result until the output register takes it
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/indexed_array_list_unit.sv
// Indexed array list unit: append, insert, delete and get on an ordered list.
// Steps: DECIDE, then DONE for append, failed requests, insert at the end and delete of
// the last entry; get waits in GET_WAIT for the RAM read; other inserts shift entries up and
// then PLACE the value, other deletes shift down, up to CAPACITY-1 entries, one a cycle.
// One request at a time; the next transfer can be taken in the cycle after the output register loads.
// Reset: rst synchronous, clears the fill count and output valid; RAM contents undefined.
module indexed_array_list_unit #(
  parameter int CAPACITY   = ial_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ial_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // op[1:0], position[7:2], value[39:8]
  input  logic [ial_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[1:0], read_value[33:2], fill_level[40:34], zero[47:41]
  output logic [ial_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(CAPACITY);

  ial_pkg::req_t         req;
  ial_pkg::res_t         res;
  logic                  res_valid, res_take;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  assign req.op       = s_tdata[1:0];
  assign req.position = s_tdata[7:2];
  assign req.value    = s_tdata[39:8];

  assign res_take = res_valid && (!m_tvalid || m_tready);

  ial_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_in    (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  ial_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: hold the result until the master-side transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_take) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'd0, res.fill_level, res.read_value, res.status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a request while busy");

  a_fail_reads_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ial_pkg::ST_OK) |-> (m_tdata[33:2] == '0))
    else $error("failed request returned nonzero read value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ial_pkg::ST_OK || m_tdata[1:0] == ial_pkg::ST_FULL
                  || m_tdata[1:0] == ial_pkg::ST_RANGE))
    else $error("undefined status code");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[40:34]) <= 32'(CAPACITY)))
    else $error("fill level above capacity");

endmodule
